// ----- sv/aps_pkg.sv -----
`timescale 1ns / 1ps
package aps_pkg;

  localparam int XW = 51;   // cordic datapath width
  localparam int ZW = 34;   // cordic angle width, turn fraction
  localparam logic signed [XW-1:0] UNIT_GAIN = XW'(652032874);

  localparam logic [1:0] REG_COMING  = 2'd0;
  localparam logic [1:0] REG_LEAVING = 2'd1;
  localparam logic [1:0] REG_FAST    = 2'd2;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sh007FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -37'sh0080000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- sv/aps_cordic.sv -----
`timescale 1ns / 1ps
module aps_cordic #(
  parameter int STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          vec_mode,
  input  logic signed [aps_pkg::XW-1:0] x0,
  input  logic signed [aps_pkg::XW-1:0] y0,
  input  logic signed [aps_pkg::ZW-1:0] z0,
  output logic                          done,
  output logic signed [aps_pkg::XW-1:0] x,
  output logic signed [aps_pkg::XW-1:0] y,
  output logic signed [aps_pkg::ZW-1:0] z
);
  import aps_pkg::*;

  localparam int CW = $clog2(STEPS);

  logic          run;
  logic          vec;
  logic [CW-1:0] cnt;
  logic          up;
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] da;

  // one micro-rotation per cycle
  assign dx = y >>> cnt;
  assign dy = x >>> cnt;
  assign da = ZW'(atan_turn(5'(cnt)));
  assign up = vec ? !(y > 0) : (z >= 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= x0;
      y   <= y0;
      z   <= z0;
      vec <= vec_mode;
    end else if (run) begin
      if (up) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - da;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + da;
      end
    end
  end

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(run)) else $error("cordic done without a run");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    run |-> !start) else $error("cordic restarted while running");
  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    done |-> !run) else $error("cordic still running after done");

endmodule

// ----- sv/armor_plate_selector_core.sv -----
`timescale 1ns / 1ps
// Picks at most one armor plate of a spinning target. One input beat describes the
// target; four plates are built at quarter turns, each plate needs one rotation
// cordic pass (cos/sin of its yaw), a pass on a shared 17x32 multiplier for
// the two rounded and saturated radius products and one vectoring cordic pass
// for the bearing. A single cordic unit does all the passes, at most eight per
// beat; in_stall stays high from an accepted beat until its item has left
// selection. A plate sitting at the origin skips its vectoring pass. The result
// sits in an output register, so the next item may be taken while the result
// beat still waits on out_stall; a finished item only waits in selection while
// the earlier result is still held. Configuration writes are always taken.
module armor_plate_selector_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic signed [15:0] body_yaw,
  input  logic signed [15:0] spin_rate,
  input  logic [30:0]        radius,
  input  logic signed [31:0] radius_offset,
  input  logic signed [31:0] height_offset,
  input  logic               clear_lock,
  input  logic               commit_lock,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               found,
  output logic [1:0]         plate_index,
  output logic signed [31:0] aim_x,
  output logic signed [31:0] aim_y,
  output logic signed [31:0] aim_z,
  output logic signed [15:0] phase_error,
  output logic signed [15:0] plate_yaw
);
  import aps_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ROT_GO   = 3'd1;
  localparam logic [2:0] S_ROT_WAIT = 3'd2;
  localparam logic [2:0] S_MUL      = 3'd3;
  localparam logic [2:0] S_BRG_GO   = 3'd4;
  localparam logic [2:0] S_BRG_WAIT = 3'd5;
  localparam logic [2:0] S_SEL      = 3'd6;

  logic [2:0] state;
  logic [1:0] k;        // plate under work
  logic [2:0] mcnt;     // multiplier phase

  // configuration registers
  logic [14:0] coming_window, leaving_window, fast_spin_limit;
  logic        held_valid;
  logic [1:0]  held_index;

  // latched item
  logic signed [31:0] cx, cy, cz, roff, hoff;
  logic [15:0]        yaw;
  logic signed [15:0] spin;
  logic [30:0]        rad;
  logic               commit;

  // per-plate results
  logic signed [31:0] px_a [4];
  logic signed [31:0] py_a [4];
  logic signed [31:0] pz_a [4];
  logic signed [15:0] pe_a [4];
  logic [15:0]        inw_a [4];
  logic signed [31:0] pxc, pyc;

  // multiplier operands, sign-magnitude
  logic [32:0] rmag;
  logic        rneg;
  logic [31:0] bmag;
  logic        bneg;
  logic [64:0] acc;
  logic signed [XW-1:0] sv;
  logic [16:0] mul_a;
  logic [48:0] mul_p;
  logic        out_load;

  // cordic hookup
  logic                 cor_start, cor_vec, cor_done;
  logic signed [XW-1:0] cor_x0, cor_y0, cor_x, cor_y;
  logic signed [ZW-1:0] cor_z0, cor_z;

  logic               odd;
  logic [15:0]        inward;
  logic signed [33:0] rsig;
  logic signed [31:0] zpre;
  logic signed [32:0] bx, by;
  logic signed [XW-1:0] bx_s, by_s;
  logic               at_origin;
  logic [64:0]        rsum;
  logic signed [35:0] term;
  logic signed [36:0] coord;
  logic signed [31:0] xabs_src;
  logic [15:0]        brg;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  assign odd    = k[0];
  assign inward = yaw + {k, 14'b0};
  assign rsig   = odd ? (34'(rad) + 34'(roff)) : 34'(rad);
  assign zpre   = {inward, 16'b0};

  // bearing is taken on the negated plate position
  assign bx        = -33'(pxc);
  assign by        = -33'(pyc);
  assign at_origin = (pxc == 32'sd0) && (pyc == 32'sd0);
  assign bx_s      = XW'(bx) <<< 16;
  assign by_s      = XW'(by) <<< 16;

  always_comb begin
    cor_vec = (state == S_BRG_GO);
    if (state == S_ROT_GO) begin
      cor_y0 = '0;
      if (zpre > 32'sh40000000 || zpre < -32'sh40000000) begin
        cor_x0 = -UNIT_GAIN;
        cor_z0 = ZW'($signed({~zpre[31], zpre[30:0]}));
      end else begin
        cor_x0 = UNIT_GAIN;
        cor_z0 = ZW'(zpre);
      end
    end else if (bx < 0) begin
      cor_x0 = -bx_s;
      cor_y0 = -by_s;
      cor_z0 = ZW'(34'sh080000000);
    end else begin
      cor_x0 = bx_s;
      cor_y0 = by_s;
      cor_z0 = '0;
    end
  end

  assign cor_start = (state == S_ROT_GO) || (state == S_BRG_GO && !at_origin);

  aps_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .start    (cor_start),
    .vec_mode (cor_vec),
    .x0       (cor_x0),
    .y0       (cor_y0),
    .z0       (cor_z0),
    .done     (cor_done),
    .x        (cor_x),
    .y        (cor_y),
    .z        (cor_z)
  );

  // shared 17x32 multiplier, low half of the radius first, then the high half
  assign mul_a = (mcnt == 3'd0 || mcnt == 3'd3) ? {1'b0, rmag[15:0]} : rmag[32:16];
  assign mul_p = 49'(mul_a) * 49'(bmag);

  // rounding of the radius product, half away from zero
  assign rsum  = acc + 65'(1 << 29);
  assign term  = (rneg ^ bneg) ? -36'($unsigned(rsum[64:30])) : 36'($unsigned(rsum[64:30]));
  assign coord = ((mcnt == 3'd2) ? 37'(cx) : 37'(cy)) - 37'(term);
  assign xabs_src = sv[XW-1] ? 32'(-sv) : 32'(sv);
  assign brg   = 16'((cor_z[31:0] + 32'h8000) >> 16);

  // result register is loaded once selection is done and the old beat has gone
  assign out_load = (state == S_SEL) && (!out_valid || !out_stall);

  // selection
  logic [16:0] pabs [4];
  logic [16:0] spin_abs;
  logic        fast, held_ok, sel_found;
  logic [1:0]  sel_best;
  logic [16:0] best_abs;
  logic        pass;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pabs[i] = pe_a[i][15] ? -17'(pe_a[i]) : 17'(pe_a[i]);
    end
    spin_abs = spin[15] ? -17'(spin) : 17'(spin);
    fast     = spin_abs > 17'(fast_spin_limit);
    held_ok  = !fast && held_valid && (pabs[held_index] <= 17'(coming_window));
    sel_found = held_ok;
    sel_best  = held_index;
    best_abs  = '0;
    pass      = 1'b0;
    if (!held_ok) begin
      sel_best = 2'd0;
      for (int i = 0; i < 4; i++) begin
        pass = !fast ||
               ((pabs[i] <= 17'(coming_window)) &&
                !(spin > 0 && 17'(pe_a[i]) > $signed(17'(leaving_window))) &&
                !(spin < 0 && 17'(pe_a[i]) < -$signed(17'(leaving_window))));
        if (pass && (!sel_found || pabs[i] < best_abs)) begin
          sel_found = 1'b1;
          sel_best  = 2'(i);
          best_abs  = pabs[i];
        end
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      k               <= '0;
      mcnt            <= '0;
      coming_window   <= 15'd4096;
      leaving_window  <= 15'd2048;
      fast_spin_limit <= 15'd512;
      held_valid      <= 1'b0;
      held_index      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COMING:  coming_window   <= cfg_data;
          REG_LEAVING: leaving_window  <= cfg_data;
          REG_FAST:    fast_spin_limit <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (clear_lock) held_valid <= 1'b0;
            k     <= '0;
            state <= S_ROT_GO;
          end
        end
        S_ROT_GO:   state <= S_ROT_WAIT;
        S_ROT_WAIT: begin
          if (cor_done) begin
            mcnt  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          mcnt <= mcnt + 1'b1;
          if (mcnt == 3'd5) state <= S_BRG_GO;
        end
        S_BRG_GO: begin
          if (at_origin) begin
            k     <= k + 1'b1;
            state <= (k == 2'd3) ? S_SEL : S_ROT_GO;
          end else begin
            state <= S_BRG_WAIT;
          end
        end
        S_BRG_WAIT: begin
          if (cor_done) begin
            k     <= k + 1'b1;
            state <= (k == 2'd3) ? S_SEL : S_ROT_GO;
          end
        end
        S_SEL: begin
          if (out_load) begin
            if (sel_found && commit) begin
              held_valid <= 1'b1;
              held_index <= sel_best;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cx     <= center_x;
      cy     <= center_y;
      cz     <= center_z;
      yaw    <= body_yaw;
      spin   <= spin_rate;
      rad    <= radius;
      roff   <= radius_offset;
      hoff   <= height_offset;
      commit <= commit_lock;
    end
    if (state == S_ROT_GO) begin
      inw_a[k] <= inward;
      rneg     <= rsig[33];
      rmag     <= rsig[33] ? 33'(-rsig) : 33'(rsig);
    end
    if (state == S_ROT_WAIT && cor_done) begin
      sv   <= cor_y;
      bneg <= cor_x[XW-1];
      bmag <= cor_x[XW-1] ? 32'(-cor_x) : 32'(cor_x);
    end
    if (state == S_MUL) begin
      case (mcnt)
        3'd0, 3'd3: acc <= 65'(mul_p);
        3'd1, 3'd4: acc <= acc + {mul_p, 16'b0};
        3'd2: begin
          pxc      <= sat32(coord);
          px_a[k]  <= sat32(coord);
          bneg     <= sv[XW-1];
          bmag     <= xabs_src;
        end
        3'd5: begin
          pyc     <= sat32(coord);
          py_a[k] <= sat32(coord);
          pz_a[k] <= odd ? sat32(37'(cz) + 37'(hoff)) : cz;
        end
        default: ;
      endcase
    end
    if (state == S_BRG_GO && at_origin) pe_a[k] <= inw_a[k] + 16'h8000;
    if (state == S_BRG_WAIT && cor_done) pe_a[k] <= inw_a[k] + 16'h8000 - brg;
    if (out_load) begin
      found <= sel_found;
      if (sel_found) begin
        plate_index <= sel_best;
        aim_x       <= px_a[sel_best];
        aim_y       <= py_a[sel_best];
        aim_z       <= pz_a[sel_best];
        phase_error <= pe_a[sel_best];
        plate_yaw   <= inw_a[sel_best];
      end else begin
        plate_index <= '0;
        aim_x       <= '0;
        aim_y       <= '0;
        aim_z       <= '0;
        phase_error <= '0;
        plate_yaw   <= '0;
      end
    end
  end

  a_result_from_sel: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_SEL)
    else $error("result beat raised outside selection");
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (plate_index == 2'd0 && aim_x == 32'sd0 &&
                               phase_error == 16'sd0))
    else $error("empty result carries data");
  a_commit_held: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_SEL && state == S_IDLE && $past(commit) && found)
      |-> (held_valid && held_index == plate_index))
    else $error("committed plate not held");

endmodule
